// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/sprd_pkg.sv =====
// Types and constants of the sprite line decoder.
package sprd_pkg;

	typedef enum logic [3:0] {
		PH_SKIP  = 4'b0001,
		PH_COUNT = 4'b0010,
		PH_PIXA  = 4'b0100,
		PH_PIXB  = 4'b1000
	} phase_t;

	localparam logic [1:0] MODE_RGB15  = 2'd1;
	localparam logic [1:0] MODE_SHADOW = 2'd2;

	localparam logic [1:0] REG_PIXEL_MODE  = 2'd0;
	localparam logic [1:0] REG_LEFT_MARGIN = 2'd1;
	localparam logic [1:0] REG_TOP_MARGIN  = 2'd2;
	localparam logic [1:0] REG_ROW_STRIDE  = 2'd3;

	localparam logic [7:0] TRANSPARENT_IDX = 8'd64;

	typedef struct packed {
		logic [1:0]  pixel_mode;
		logic [11:0] left_margin;
	} core_cfg_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] column;
		logic [7:0]  span_length;
		logic [15:0] pixel_value;
	} emit_t;

endpackage

// ===== design/sprd_if.sv =====
// Valid/ready channel interfaces for input bytes and output pixels.
interface sprd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        line_start;
	logic [11:0] line_row;

	modport source (output valid, data_byte, line_start, line_row, input ready);
	modport sink (input valid, data_byte, line_start, line_row, output ready);
endinterface

interface sprd_out_if;
	logic        valid;
	logic        ready;
	logic [25:0] pixel_index;
	logic [7:0]  span_length;
	logic [15:0] pixel_value;

	modport source (output valid, pixel_index, span_length, pixel_value, input ready);
	modport sink (input valid, pixel_index, span_length, pixel_value, output ready);
endinterface

// ===== design/sprite_rle_line_decoder.sv =====
// Sprite line decoder top level: config registers, decode stage, index multiply stage.
// An item that makes a pixel passes the stage-one and stage-two registers before it shows on the output.
// Throughput: one byte per cycle; input stalls only when both stages are full and the
// output is not taken.
// The index stage holds one 13x13 multiply and a 26-bit add.
// Reset clears decode state and the pipeline; registers reset to zero, row_stride to one.
module sprite_rle_line_decoder (
	input  logic              clk,
	input  logic              arst_n,
	sprd_in_if.sink           in_ch,
	sprd_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [12:0]       cfg_data
);

	logic [1:0]  pixel_mode_q;
	logic [11:0] left_margin_q;
	logic [11:0] top_margin_q;
	logic [12:0] row_stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q  <= '0;
			left_margin_q <= '0;
			top_margin_q  <= '0;
			row_stride_q  <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				sprd_pkg::REG_PIXEL_MODE:  pixel_mode_q  <= cfg_data[1:0];
				sprd_pkg::REG_LEFT_MARGIN: left_margin_q <= cfg_data[11:0];
				sprd_pkg::REG_TOP_MARGIN:  top_margin_q  <= cfg_data[11:0];
				sprd_pkg::REG_ROW_STRIDE:  row_stride_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic valid_s1, valid_s2;
	logic adv_s1, adv_s2, accept;

	assign adv_s2 = !valid_s2 || out_ch.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ch.ready = adv_s1;
	assign accept = in_ch.valid && adv_s1;

	sprd_pkg::core_cfg_t core_cfg;
	sprd_pkg::emit_t     emit;

	assign core_cfg.pixel_mode  = pixel_mode_q;
	assign core_cfg.left_margin = left_margin_q;

	sprd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (in_ch.data_byte),
		.line_start (in_ch.line_start),
		.cfg        (core_cfg),
		.emit       (emit)
	);

	logic [12:0] row_sum_s1;
	logic [15:0] column_s1;
	logic [7:0]  span_s1, span_s2;
	logic [15:0] value_s1, value_s2;
	logic [25:0] index_s2;
	logic [25:0] product;

	assign product = {13'd0, row_sum_s1} * {13'd0, row_stride_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= accept && emit.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			row_sum_s1 <= {1'b0, in_ch.line_row} + {1'b0, top_margin_q};
			column_s1  <= emit.column;
			span_s1    <= emit.span_length;
			value_s1   <= emit.pixel_value;
		end
		if (adv_s2) begin
			index_s2 <= product + {10'd0, column_s1};
			span_s2  <= span_s1;
			value_s2 <= value_s1;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.pixel_index = index_s2;
	assign out_ch.span_length = span_s2;
	assign out_ch.pixel_value = value_s2;

endmodule

// ===== design/sprd_core.sv =====
// Run-length line state machine: phase, column, run count and held low byte.
module sprd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                line_start,
	input  sprd_pkg::core_cfg_t cfg,
	output sprd_pkg::emit_t     emit
);

	sprd_pkg::phase_t phase_q, phase_d;
	logic [15:0] column_q, column_d;
	logic [7:0]  run_left_q, run_left_d;
	logic [7:0]  low_hold_q, low_hold_d;
	logic [7:0]  run_m1;

	assign run_m1 = run_left_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		column_d     = column_q;
		run_left_d   = run_left_q;
		low_hold_d   = low_hold_q;
		emit.valid       = 1'b0;
		emit.column      = column_q;
		emit.span_length = 8'd1;
		emit.pixel_value = {8'd0, data_byte};
		if (line_start) begin
			column_d = {4'd0, cfg.left_margin} + {8'd0, data_byte};
			phase_d  = sprd_pkg::PH_COUNT;
		end else begin
			case (phase_q)
				sprd_pkg::PH_SKIP: begin
					column_d = column_q + {8'd0, data_byte};
					phase_d  = sprd_pkg::PH_COUNT;
				end
				sprd_pkg::PH_COUNT: begin
					if (data_byte == 8'd0) begin
						phase_d = sprd_pkg::PH_SKIP;
					end else if (cfg.pixel_mode == sprd_pkg::MODE_SHADOW) begin
						emit.valid       = 1'b1;
						emit.span_length = data_byte;
						emit.pixel_value = 16'd1;
						column_d = column_q + {8'd0, data_byte};
						phase_d  = sprd_pkg::PH_SKIP;
					end else begin
						run_left_d = data_byte;
						phase_d    = sprd_pkg::PH_PIXA;
					end
				end
				sprd_pkg::PH_PIXA: begin
					if (cfg.pixel_mode == sprd_pkg::MODE_RGB15) begin
						low_hold_d = data_byte;
						phase_d    = sprd_pkg::PH_PIXB;
					end else begin
						emit.valid = 1'b1;
						if (data_byte == sprd_pkg::TRANSPARENT_IDX) begin
							emit.pixel_value = 16'd0;
						end
						column_d   = column_q + 16'd1;
						run_left_d = run_m1;
						phase_d    = (run_m1 == 8'd0) ? sprd_pkg::PH_SKIP : sprd_pkg::PH_PIXA;
					end
				end
				default: begin
					emit.valid       = 1'b1;
					emit.pixel_value = {data_byte, low_hold_q};
					column_d   = column_q + 16'd1;
					run_left_d = run_m1;
					phase_d    = (run_m1 == 8'd0) ? sprd_pkg::PH_SKIP : sprd_pkg::PH_PIXA;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= sprd_pkg::PH_SKIP;
			column_q   <= '0;
			run_left_q <= '0;
			low_hold_q <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			column_q   <= column_d;
			run_left_q <= run_left_d;
			low_hold_q <= low_hold_d;
		end
	end

endmodule

// ===== design/sprd_checker.sv =====
// Port-level checker for the sprite line decoder, bound to the top level.
`include "assert_macros.svh"

module sprd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [25:0] pixel_index,
	input logic [7:0]  span_length,
	input logic [15:0] pixel_value
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_index) && $stable(span_length) && $stable(pixel_value))
	`ASSERT_SAME(a_span_nonzero, clk, arst_n, out_valid, span_length != 8'd0)
	`ASSERT_SAME(a_long_span_shadow, clk, arst_n, out_valid && (span_length != 8'd1), pixel_value == 16'd1)
	`ASSERT_SAME(a_stall_from_output, clk, arst_n, in_valid && !in_ready, out_valid && !out_ready)

endmodule

bind sprite_rle_line_decoder sprd_checker u_sprd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.pixel_index (out_ch.pixel_index),
	.span_length (out_ch.span_length),
	.pixel_value (out_ch.pixel_value)
);
